// ----- rtl/core/hoe_pkg.sv -----
package hoe_pkg;

	localparam int MF_W = 31;
	localparam int DIV_STEPS = 48;
	localparam int DIV_LAT = DIV_STEPS + 1;

	typedef logic signed [31:0] q_t;

	typedef logic [1:0] status_t;
	localparam status_t ST_OK  = 2'd0;
	localparam status_t ST_SAT = 2'd1;
	localparam status_t ST_BAD = 2'd2;

	typedef struct packed {
		q_t   v;
		logic sat;
	} sat32_t;

	function automatic sat32_t f_qscale(input logic signed [63:0] p);
		logic signed [63:0] t;
		sat32_t r;
		t = (p + (p[63] ? 64'sd65535 : 64'sd0)) >>> 16;
		if (t > 64'sd2147483647) begin
			r.v = 32'sh7fffffff;
			r.sat = 1'b1;
		end else if (t < -64'sd2147483648) begin
			r.v = 32'sh80000000;
			r.sat = 1'b1;
		end else begin
			r.v = t[31:0];
			r.sat = 1'b0;
		end
		return r;
	endfunction

	function automatic sat32_t f_qsub(input q_t a, input q_t b);
		logic signed [32:0] d;
		sat32_t r;
		d = {a[31], a} - {b[31], b};
		if (d[32] != d[31]) begin
			r.v = d[32] ? 32'sh80000000 : 32'sh7fffffff;
			r.sat = 1'b1;
		end else begin
			r.v = d[31:0];
			r.sat = 1'b0;
		end
		return r;
	endfunction

endpackage

// ----- rtl/core/hoe_if.sv -----
interface hoe_in_if;
	logic              valid;
	logic              ready;
	logic signed [31:0] mag_x;
	logic signed [31:0] mag_y;
	logic signed [31:0] mag_z;
	logic signed [31:0] cur_x;
	logic signed [31:0] cur_y;
	logic signed [31:0] cur_z;
	logic signed [31:0] density;
	logic signed [31:0] mom_x;
	logic signed [31:0] mom_y;
	logic signed [31:0] mom_z;

	modport source (output valid, mag_x, mag_y, mag_z, cur_x, cur_y, cur_z, density,
		mom_x, mom_y, mom_z, input ready);
	modport sink (input valid, mag_x, mag_y, mag_z, cur_x, cur_y, cur_z, density,
		mom_x, mom_y, mom_z, output ready);
endinterface

interface hoe_out_if;
	logic              valid;
	logic              ready;
	logic signed [31:0] efield_x;
	logic signed [31:0] efield_y;
	logic signed [31:0] efield_z;
	logic [1:0]         status;

	modport source (output valid, efield_x, efield_y, efield_z, status, input ready);
	modport sink (input valid, efield_x, efield_y, efield_z, status, output ready);
endinterface

// ----- rtl/core/hoe_divider.sv -----
module hoe_divider (
	input  logic          clk,
	input  logic          en,
	input  hoe_pkg::q_t   num,
	input  logic [30:0]   den,
	output hoe_pkg::q_t   quo,
	output logic          sat
);
	import hoe_pkg::*;

	logic [30:0] rem_q [DIV_STEPS];
	logic [47:0] w_q   [DIV_STEPS];
	logic [30:0] den_q [DIV_STEPS];
	logic        neg_q [DIV_STEPS];
	q_t          quo_q;
	logic        sat_q;
	logic [31:0] mag;
	logic [47:0] qm;

	function automatic logic [78:0] f_step(input logic [30:0] r, input logic [47:0] w,
			input logic [30:0] d);
		logic [31:0] trial;
		logic        ge;
		logic [31:0] nr;
		trial = {r, w[47]};
		ge = trial >= {1'b0, d};
		nr = ge ? trial - {1'b0, d} : trial;
		return {nr[30:0], w[46:0], ge};
	endfunction

	assign mag = num[31] ? 32'(-num) : 32'(num);

	always_ff @(posedge clk) begin
		if (en) begin
			{rem_q[0], w_q[0]} <= f_step(31'd0, {mag, 16'd0}, den);
			den_q[0] <= den;
			neg_q[0] <= num[31];
			for (int k = 1; k < DIV_STEPS; k++) begin
				{rem_q[k], w_q[k]} <= f_step(rem_q[k-1], w_q[k-1], den_q[k-1]);
				den_q[k] <= den_q[k-1];
				neg_q[k] <= neg_q[k-1];
			end
		end
	end

	assign qm = w_q[DIV_STEPS-1];

	always_ff @(posedge clk) begin
		if (en) begin
			if (!neg_q[DIV_STEPS-1]) begin
				if (|qm[47:31]) begin
					quo_q <= 32'sh7fffffff;
					sat_q <= 1'b1;
				end else begin
					quo_q <= qm[31:0];
					sat_q <= 1'b0;
				end
			end else begin
				if ((|qm[47:32]) || (qm[31] && (|qm[30:0]))) begin
					quo_q <= 32'sh80000000;
					sat_q <= 1'b1;
				end else begin
					quo_q <= 32'(-qm[31:0]);
					sat_q <= 1'b0;
				end
			end
		end
	end

	assign quo = quo_q;
	assign sat = sat_q;
endmodule

// ----- rtl/core/hall_ohm_electric_field.sv -----
// An accepted item passes through stages s1 to s3, the divider pipeline and stages s4 to s7 to its result.
// Throughput: one item per cycle while the output is not stalled; the three 48-step restoring dividers set the depth.
// All stages advance together and hold while the output item waits.
// Reset clears the stage valid bits and sets the mass factor to 1.0 (65536).
module hall_ohm_electric_field (
	input  logic                     clk,
	input  logic                     arst_n,
	hoe_in_if.sink                   inp,
	hoe_out_if.source                res,
	input  logic                     cfg_valid,
	output logic                     cfg_ready,
	input  logic [hoe_pkg::MF_W-1:0] cfg_data
);
	import hoe_pkg::*;

	typedef struct packed {
		logic        v;
		logic        bad;
		logic        sat;
		q_t [2:0]    mag;
	} side_t;

	logic            en;
	logic [MF_W-1:0] mass_q;

	logic                v_s1;
	logic signed [63:0]  prod_s1 [3];
	q_t [2:0]            mom_s1, mag_s1;
	q_t                  rho_s1;

	logic     v_s2, sat_s2;
	q_t [2:0] mj_s2, mom_s2, mag_s2;
	q_t       rho_s2;

	logic     v_s3, sat_s3;
	q_t [2:0] num_s3, mag_s3;
	q_t       rho_s3;

	side_t    side_q [DIV_LAT];
	q_t       quo [3];
	logic     qsat [3];

	logic     v_s4, bad_s4, sat_s4;
	q_t [2:0] u_s4, mag_s4;

	logic               v_s5, bad_s5, sat_s5;
	logic signed [63:0] p_s5 [6];

	logic     v_s6, bad_s6, sat_s6;
	q_t [5:0] t_s6;

	logic     v_s7;
	q_t [2:0] e_s7;
	status_t  st_s7;

	assign en = !v_s7 || res.ready;
	assign inp.ready = en;
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mass_q <= MF_W'(65536);
		end else if (cfg_valid) begin
			mass_q <= cfg_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
			v_s5 <= 1'b0;
			v_s6 <= 1'b0;
			v_s7 <= 1'b0;
			for (int k = 0; k < DIV_LAT; k++) begin
				side_q[k] <= '0;
			end
		end else if (en) begin
			v_s1 <= inp.valid;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
			side_q[0] <= '{v: v_s3, bad: rho_s3 <= 0, sat: sat_s3, mag: mag_s3};
			for (int k = 1; k < DIV_LAT; k++) begin
				side_q[k] <= side_q[k-1];
			end
			v_s4 <= side_q[DIV_LAT-1].v;
			v_s5 <= v_s4;
			v_s6 <= v_s5;
			v_s7 <= v_s6;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			prod_s1[0] <= signed'({33'd0, mass_q}) * 64'(inp.cur_x);
			prod_s1[1] <= signed'({33'd0, mass_q}) * 64'(inp.cur_y);
			prod_s1[2] <= signed'({33'd0, mass_q}) * 64'(inp.cur_z);
			mom_s1 <= {inp.mom_z, inp.mom_y, inp.mom_x};
			mag_s1 <= {inp.mag_z, inp.mag_y, inp.mag_x};
			rho_s1 <= inp.density;
		end
	end

	always_ff @(posedge clk) begin
		sat32_t r;
		logic   s;
		if (en) begin
			s = 1'b0;
			for (int i = 0; i < 3; i++) begin
				r = f_qscale(prod_s1[i]);
				mj_s2[i] <= r.v;
				s = s | r.sat;
			end
			sat_s2 <= s;
			mom_s2 <= mom_s1;
			mag_s2 <= mag_s1;
			rho_s2 <= rho_s1;
		end
	end

	always_ff @(posedge clk) begin
		sat32_t r;
		logic   s;
		if (en) begin
			s = sat_s2;
			for (int i = 0; i < 3; i++) begin
				r = f_qsub(mom_s2[i], mj_s2[i]);
				num_s3[i] <= r.v;
				s = s | r.sat;
			end
			sat_s3 <= s;
			mag_s3 <= mag_s2;
			rho_s3 <= rho_s2;
		end
	end

	for (genvar i = 0; i < 3; i++) begin : g_div
		hoe_divider u_div (
			.clk (clk),
			.en  (en),
			.num (num_s3[i]),
			.den (rho_s3[30:0]),
			.quo (quo[i]),
			.sat (qsat[i])
		);
	end

	always_ff @(posedge clk) begin
		if (en) begin
			u_s4 <= {quo[2], quo[1], quo[0]};
			mag_s4 <= side_q[DIV_LAT-1].mag;
			bad_s4 <= side_q[DIV_LAT-1].bad;
			sat_s4 <= side_q[DIV_LAT-1].sat | qsat[0] | qsat[1] | qsat[2];
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			p_s5[0] <= 64'(u_s4[2]) * 64'(mag_s4[1]);
			p_s5[1] <= 64'(u_s4[1]) * 64'(mag_s4[2]);
			p_s5[2] <= 64'(u_s4[0]) * 64'(mag_s4[2]);
			p_s5[3] <= 64'(u_s4[2]) * 64'(mag_s4[0]);
			p_s5[4] <= 64'(u_s4[1]) * 64'(mag_s4[0]);
			p_s5[5] <= 64'(u_s4[0]) * 64'(mag_s4[1]);
			bad_s5 <= bad_s4;
			sat_s5 <= sat_s4;
		end
	end

	always_ff @(posedge clk) begin
		sat32_t r;
		logic   s;
		if (en) begin
			s = sat_s5;
			for (int k = 0; k < 6; k++) begin
				r = f_qscale(p_s5[k]);
				t_s6[k] <= r.v;
				s = s | r.sat;
			end
			sat_s6 <= s;
			bad_s6 <= bad_s5;
		end
	end

	always_ff @(posedge clk) begin
		sat32_t r;
		logic   s;
		if (en) begin
			s = sat_s6;
			for (int i = 0; i < 3; i++) begin
				r = f_qsub(t_s6[2*i], t_s6[2*i+1]);
				e_s7[i] <= bad_s6 ? 32'sd0 : r.v;
				s = s | r.sat;
			end
			st_s7 <= bad_s6 ? ST_BAD : (s ? ST_SAT : ST_OK);
		end
	end

	assign res.valid    = v_s7;
	assign res.efield_x = e_s7[0];
	assign res.efield_y = e_s7[1];
	assign res.efield_z = e_s7[2];
	assign res.status   = st_s7;

	a_status_code: assert property (@(posedge clk) disable iff (!arst_n)
		res.valid |-> (res.status == ST_OK || res.status == ST_SAT || res.status == ST_BAD))
		else $error("status code out of range");

	a_bad_zero: assert property (@(posedge clk) disable iff (!arst_n)
		res.valid && res.status == ST_BAD |->
		res.efield_x == 0 && res.efield_y == 0 && res.efield_z == 0)
		else $error("nonzero field for a bad density");

	a_stall_only: assert property (@(posedge clk) disable iff (!arst_n)
		!inp.ready |-> res.valid && !res.ready)
		else $error("input held off without an output stall");
endmodule
